### rtl/hbc_pkg.sv
package hbc_pkg;

	localparam int unsigned SETS_DEF = 16;
	localparam int unsigned WAYS_DEF = 8;
	localparam int unsigned DEV_W    = 8;
	localparam int unsigned BLK_W    = 32;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned WAYF_W   = 3;
	localparam int unsigned QD       = 2;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		REQ_GET     = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_PIN     = 2'd2,
		REQ_UNPIN   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_UNDERFLOW = 2'd3
	} status_t;

	// classified request handed from front to back
	typedef struct packed {
		req_t                req;
		logic [DEV_W-1:0]    dev;
		logic [BLK_W-1:0]    blk;
		logic [WAYF_W-1:0]   way;
		logic [7:0]          set;
	} cmd_t;

	typedef struct packed {
		logic [WAYF_W-1:0] result_way;
		logic              hit;
		logic              needs_fill;
		status_t           status;
	} rsp_t;

endpackage

### rtl/hbc_front.sv
module hbc_front #(
	parameter int unsigned SETS = hbc_pkg::SETS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      req_type,
	input  logic [hbc_pkg::DEV_W-1:0]       dev,
	input  logic [hbc_pkg::BLK_W-1:0]       blockno,
	input  logic [hbc_pkg::WAYF_W-1:0]      way,
	output logic                            cmd_valid,
	input  logic                            cmd_take,
	output hbc_pkg::cmd_t                   cmd
);

	localparam int unsigned QW = $clog2(hbc_pkg::QD);
	// 2^8, 2^16 and 2^24 reduced by the set count, for a bytewise fold of the sum
	localparam logic [7:0]  R1 = 8'((32'd1 << 8) % SETS);
	localparam logic [7:0]  R2 = 8'((32'd1 << 16) % SETS);
	localparam logic [7:0]  R3 = 8'((32'd1 << 24) % SETS);
	// reciprocal of the set count, exact for any 18-bit folded value
	localparam int unsigned RK = 26;
	localparam logic [26:0] RM = 27'(((64'd1 << RK) + 64'(SETS) - 64'd1) / 64'(SETS));

	hbc_pkg::cmd_t         q_q [hbc_pkg::QD];
	logic [QW-1:0]         wp_q, rp_q;
	logic [QW:0]           cnt_q;
	logic [hbc_pkg::BLK_W-1:0] sum;
	logic [17:0]           fold;
	logic [43:0]           prod;
	logic [17:0]           rem;
	logic                  take_in, enq;
	logic                  v_s1, v_s2;
	hbc_pkg::cmd_t         cmd_s1, cmd_s2;
	logic [17:0]           fold_s1, fold_s2;
	logic [17:0]           quo_s2;
	hbc_pkg::cmd_t         cin;

	assign sum  = blockno + {{(hbc_pkg::BLK_W-hbc_pkg::DEV_W){1'b0}}, dev};
	// same residue as the sum, at most 18 bits
	assign fold = 18'(sum[7:0]) + 18'(sum[15:8]) * 18'(R1) + 18'(sum[23:16]) * 18'(R2)
	            + 18'(sum[31:24]) * 18'(R3);
	assign prod = 44'(fold_s1) * 44'(RM);
	assign rem  = fold_s2 - quo_s2 * 18'(SETS);

	always_comb begin
		cin     = cmd_s2;
		cin.set = rem[7:0];
	end

	assign take_in   = push && !full;
	assign enq       = v_s2;
	assign full      = v_s1 || v_s2 || (cnt_q == (QW+1)'(hbc_pkg::QD));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1.req <= hbc_pkg::req_t'(req_type);
			cmd_s1.dev <= dev;
			cmd_s1.blk <= blockno;
			cmd_s1.way <= way;
			cmd_s1.set <= '0;
			fold_s1    <= fold;
		end
		if (v_s1) begin
			cmd_s2  <= cmd_s1;
			fold_s2 <= fold_s1;
			quo_s2  <= prod[43:26];
		end
		if (enq)
			q_q[wp_q] <= cin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			v_s1 <= take_in;
			v_s2 <= v_s1;
			if (enq)
				wp_q <= wp_q + 1'b1;
			if (cmd_take)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(enq) - (QW+1)'(cmd_take);
		end
	end

endmodule

### rtl/hbc_back.sv
module hbc_back #(
	parameter int unsigned SETS = hbc_pkg::SETS_DEF,
	parameter int unsigned WAYS = hbc_pkg::WAYS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_take,
	input  hbc_pkg::cmd_t  cmd,
	output logic           empty,
	input  logic           pop,
	output hbc_pkg::rsp_t  rsp
);

	localparam int unsigned WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned SW  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned EW  = SW + WW;

	typedef struct packed {
		logic [hbc_pkg::DEV_W-1:0] dev;
		logic [hbc_pkg::BLK_W-1:0] blk;
		logic [hbc_pkg::CNT_W-1:0] cnt;
		logic                      vld;
		logic [WW-1:0]             rank;
	} ent_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_EVAL  = 4'b0100,
		S_WRITE = 4'b1000
	} st_t;

	// set is kept as one wide row of all its ways
	ent_t          mem [SETS][WAYS];
	ent_t          row_s1 [WAYS];
	ent_t          nrow [WAYS];
	logic          wr_en;
	logic          adv;
	st_t           st_q;
	hbc_pkg::cmd_t c_q;
	hbc_pkg::rsp_t res, out_q;
	logic          full_q;
	logic [SW-1:0] set_w;
	logic [SW:0]   clr_q;
	logic          clr_done;

	assign set_w    = SW'(c_q.set);
	assign clr_done = clr_q[SW] || (clr_q == (SW+1)'(SETS));

	always_ff @(posedge clk) begin
		if (!clr_done) begin
			for (int w = 0; w < WAYS; w++) begin
				mem[clr_q[SW-1:0]][w].dev  <= '0;
				mem[clr_q[SW-1:0]][w].blk  <= '0;
				mem[clr_q[SW-1:0]][w].cnt  <= '0;
				mem[clr_q[SW-1:0]][w].vld  <= 1'b0;
				mem[clr_q[SW-1:0]][w].rank <= WW'(w);
			end
		end else if (wr_en) begin
			for (int w = 0; w < WAYS; w++)
				mem[set_w][w] <= nrow[w];
		end
		for (int w = 0; w < WAYS; w++)
			row_s1[w] <= mem[set_w][w];
	end

	always_comb begin
		logic           hf, ff;
		logic [WW-1:0]  hw, fw, hr, fr, ow, orank;
		logic           inr;
		for (int w = 0; w < WAYS; w++) nrow[w] = row_s1[w];
		res = '0;
		hf = 1'b0; ff = 1'b0; hw = '0; fw = '0; hr = '0; fr = '0;
		ow = WW'(c_q.way);
		inr = (32'(c_q.way) < WAYS);
		orank = row_s1[ow].rank;
		for (int w = 0; w < WAYS; w++) begin
			if (row_s1[w].dev == c_q.dev && row_s1[w].blk == c_q.blk &&
			    (!hf || row_s1[w].rank > hr)) begin
				hf = 1'b1; hw = WW'(w); hr = row_s1[w].rank;
			end
			if (row_s1[w].cnt == '0 && (!ff || row_s1[w].rank < fr)) begin
				ff = 1'b1; fw = WW'(w); fr = row_s1[w].rank;
			end
		end
		res.result_way = c_q.way;
		res.status     = hbc_pkg::ST_OK;
		case (c_q.req)
			hbc_pkg::REQ_GET: begin
				if (hf) begin
					res.result_way = hbc_pkg::WAYF_W'(hw);
					res.hit = 1'b1;
					if (row_s1[hw].cnt == hbc_pkg::CNT_MAX)
						res.status = hbc_pkg::ST_OVERFLOW;
					else begin
						res.needs_fill  = !row_s1[hw].vld;
						nrow[hw].cnt = row_s1[hw].cnt + 1'b1;
						nrow[hw].vld = 1'b1;
					end
				end else if (ff) begin
					res.result_way = hbc_pkg::WAYF_W'(fw);
					res.needs_fill = 1'b1;
					nrow[fw].dev = c_q.dev;
					nrow[fw].blk = c_q.blk;
					nrow[fw].cnt = hbc_pkg::CNT_W'(1);
					nrow[fw].vld = 1'b1;
				end else begin
					res.result_way = '0;
					res.status = hbc_pkg::ST_NO_FREE;
				end
			end
			hbc_pkg::REQ_PIN: begin
				if (inr) begin
					if (row_s1[ow].cnt == hbc_pkg::CNT_MAX)
						res.status = hbc_pkg::ST_OVERFLOW;
					else
						nrow[ow].cnt = row_s1[ow].cnt + 1'b1;
				end
			end
			default: begin
				if (inr) begin
					if (row_s1[ow].cnt == '0)
						res.status = hbc_pkg::ST_UNDERFLOW;
					else begin
						nrow[ow].cnt = row_s1[ow].cnt - 1'b1;
						if (c_q.req == hbc_pkg::REQ_RELEASE &&
						    row_s1[ow].cnt == hbc_pkg::CNT_W'(1)) begin
							for (int w = 0; w < WAYS; w++)
								if (row_s1[w].rank > orank)
									nrow[w].rank = row_s1[w].rank - 1'b1;
							nrow[ow].rank = WW'(WAYS-1);
						end
					end
				end
			end
		endcase
	end

	assign cmd_take = (st_q == S_IDLE) && cmd_valid && clr_done;
	assign wr_en    = (st_q == S_WRITE);
	// result register free or being emptied this cycle
	assign adv      = (st_q == S_EVAL) && (!full_q || pop);
	assign empty    = !full_q;
	assign rsp      = out_q;

	always_ff @(posedge clk) begin
		if (cmd_take) c_q <= cmd;
		if (adv) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			full_q <= 1'b0;
			clr_q  <= '0;
		end else begin
			if (!clr_done) clr_q <= clr_q + 1'b1;
			full_q <= adv || (full_q && !pop);
			case (st_q)
				S_IDLE:  if (cmd_take) st_q <= S_READ;
				S_READ:  st_q <= S_EVAL;
				S_EVAL:  if (adv) st_q <= S_WRITE;
				S_WRITE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/hashed_block_cache_tag_lru.sv
// Tag and replacement store of a hashed set-associative disk block cache.
// Requests enter through a queue-style port: push/full with req_type, dev,
// blockno and way; a beat is taken when push is high and full is low.
// Results leave the same way: while empty is low the oldest result sits on
// result_way, hit, needs_fill and status, and pop takes it.
// A front end reduces (dev + blockno) to a set index in two registered steps
// (byte fold, then a reciprocal multiply) and parks the request in a two-entry
// queue; full is high while a request is being classified or the queue is
// full. The back end reads the whole set row, evaluates hit/victim/count
// updates and writes the row back.
// The back end serves one request at a time (idle, read, evaluate, write on
// the single-ported set memory); the front takes no new request while one
// is being classified. The back end is the slower of the two, so it sets
// the rate.
// After reset a clearing pass over all SETS sets initialises the tag store
// (ranks set to way index); requests queue up but are not served until it
// ends. A stalled result (pop low) holds the back end in evaluation, while
// the front keeps taking requests until its queue fills.
module hashed_block_cache_tag_lru #(
	parameter int unsigned SETS = hbc_pkg::SETS_DEF,
	parameter int unsigned WAYS = hbc_pkg::WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [7:0]  dev,
	input  logic [31:0] blockno,
	input  logic [2:0]  way,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  result_way,
	output logic        hit,
	output logic        needs_fill,
	output logic [1:0]  status
);

	logic          cmd_valid, cmd_take;
	hbc_pkg::cmd_t cmd;
	hbc_pkg::rsp_t rsp;

	hbc_front #(.SETS(SETS)) u_front (
		.clk, .arst_n, .push, .full, .req_type, .dev, .blockno, .way,
		.cmd_valid, .cmd_take, .cmd
	);

	hbc_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd, .empty, .pop, .rsp
	);

	assign result_way = rsp.result_way;
	assign hit        = rsp.hit;
	assign needs_fill = rsp.needs_fill;
	assign status     = rsp.status;

endmodule

### rtl/hbc_checker.sv
module hbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [2:0] result_way,
	input logic       hit,
	input logic       needs_fill,
	input logic [1:0] status
);

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({full, empty}))
		else $error("handshake flag unknown");

	a_nofree: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == hbc_pkg::ST_NO_FREE) |-> (result_way == 3'd0 && !hit && !needs_fill))
		else $error("no-free result carries payload");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_way) && $stable(status)))
		else $error("result changed while stalled");

	a_fill_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && needs_fill) |-> (status == hbc_pkg::ST_OK))
		else $error("fill requested on a failed request");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == hbc_pkg::ST_OVERFLOW) |-> !needs_fill)
		else $error("overflow reported with fill");

endmodule

bind hashed_block_cache_tag_lru hbc_checker u_chk (.*);
